>>> design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/ntpcal_pkg.sv
// Package: constants and stage payload types of the NTP to calendar converter
package ntpcal_pkg;

  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

  // Seconds per day is 2^7 * 675; floor(y / 675) = (y * RECIP_675) >> 35 for y < 2^25
  localparam logic [24:0] DAY_ODD_FACTOR  = 25'd675;
  localparam logic [25:0] RECIP_675       = 26'd50903317;
  localparam int unsigned RECIP_675_SHIFT = 35;

  // days from 0000-03-01 to 1970-01-01, minus 400-year eras: 719468 - 4*146097
  localparam logic [17:0] DAYS_TO_EPOCH_IN_ERA = 18'd135080;
  localparam logic [17:0] DAYS_PER_400Y   = 18'd146097;
  localparam logic [17:0] ERA_LAST_DAY    = 18'd146096;
  localparam logic [17:0] DAYS_PER_100Y   = 18'd36524;
  localparam logic [17:0] DAYS_PER_200Y   = 18'd73048;
  localparam logic [17:0] DAYS_PER_300Y   = 18'd109572;
  localparam logic [17:0] DAYS_PER_YEAR   = 18'd365;

  // floor(y / 365) for y < 2^18
  localparam logic [15:0] RECIP_365       = 16'd45965;
  localparam int unsigned RECIP_365_SHIFT = 24;
  // floor(y / 153) for y < 2048
  localparam logic [10:0] RECIP_153       = 11'd1714;
  localparam int unsigned RECIP_153_SHIFT = 18;

  // Seconds per hour is 2^4 * 225; floor(y / 225) for y < 7199
  localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [12:0] RECIP_225       = 13'd4661;
  localparam int unsigned RECIP_225_SHIFT = 20;
  // Seconds per minute is 2^2 * 15; floor(y / 15) for y < 2^10
  localparam logic [11:0] SECS_PER_MIN    = 12'd60;
  localparam logic [10:0] RECIP_15        = 11'd1093;
  localparam int unsigned RECIP_15_SHIFT  = 14;

  localparam logic [11:0] BASE_YEAR       = 12'd1600;
  localparam logic [11:0] YEARS_PER_ERA   = 12'd400;

  // Era day and seconds-of-day split carried between stages
  typedef struct packed {
    logic [31:0] unix_seconds;
    logic        era_hi;
    logic [17:0] doe;
    logic [16:0] sod;
  } split_t;

  // Civil date and time of day
  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } result_t;

endpackage

>>> design/ntpcal_split.sv
// Front stages: offset subtract, day count, then era day and seconds-of-day split
module ntpcal_split import ntpcal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [31:0] in_ntp,
  output logic        out_vld,
  output split_t      out_data
);

  logic        v1_r;
  logic        v2_r;
  logic        v3_r;
  logic [31:0] unix1_r;
  logic [31:0] unix2_r;
  logic [15:0] days2_r;
  split_t      d3_r;
  logic [50:0] day_prod;
  logic [15:0] days_nxt;
  logic [9:0]  sod_hi;
  logic [17:0] z;
  split_t      d3_nxt;

  // Divide by 86400: drop the 2^7 factor, then multiply by the reciprocal of 675
  always_comb begin
    day_prod = 51'(unix1_r[31:7]) * 51'(RECIP_675);
    days_nxt = 16'(day_prod >> RECIP_675_SHIFT);
  end

  // Split off the seconds of day and fold the day count into its 400-year era
  always_comb begin
    sod_hi = 10'(unix2_r[31:7] - 25'(days2_r) * DAY_ODD_FACTOR);
    z      = 18'(days2_r) + DAYS_TO_EPOCH_IN_ERA;
    d3_nxt.unix_seconds = unix2_r;
    d3_nxt.era_hi       = (z >= DAYS_PER_400Y);
    d3_nxt.doe          = d3_nxt.era_hi ? z - DAYS_PER_400Y : z;
    d3_nxt.sod          = {sod_hi, unix2_r[6:0]};
  end

  // Advance the valid bits of stages one to three
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unix1_r <= in_ntp - NTP_UNIX_OFFSET;
      unix2_r <= unix1_r;
      days2_r <= days_nxt;
      d3_r    <= d3_nxt;
    end
  end

  assign out_vld  = v3_r;
  assign out_data = d3_r;

endmodule

>>> design/ntp_seconds_to_calendar.sv
// Top level: pipelined NTP seconds to Unix seconds and civil date conversion
//   channel | dir | ports
//   in      | in  | in_valid, in_stall, in_ntp_seconds
//   out     | out | out_valid, out_stall, out_* fields
// Eight register stages; one beat may enter every cycle while in_stall is low.
// The pipeline advances as a whole while the output stage is empty or taken.
// in_stall is high exactly while a result waits under out_stall.
// Reset clears the valid bits only; no clearing pass.
module ntp_seconds_to_calendar import ntpcal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_ntp_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_unix_seconds,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  logic        adv;
  logic        sv;
  split_t      sd;
  logic        v4_r, v5_r, v6_r, v7_r, v8_r;
  split_t      d4_r;
  logic [17:0] num4_r;
  logic [4:0]  hour4_r;
  logic [31:0] unix5_r;
  logic        era5_r;
  logic [17:0] doe5_r;
  logic [4:0]  hour5_r;
  logic [8:0]  yoe5_r;
  logic [11:0] rem5_r;
  logic [31:0] unix6_r;
  logic        era6_r;
  logic [8:0]  yoe6_r;
  logic [4:0]  hour6_r;
  logic [11:0] rem6_r;
  logic [8:0]  doy6_r;
  logic [5:0]  min6_r;
  logic [31:0] unix7_r;
  logic        era7_r;
  logic [8:0]  yoe7_r;
  logic [4:0]  hour7_r;
  logic [5:0]  min7_r;
  logic [5:0]  sec7_r;
  logic [8:0]  doy7_r;
  logic [3:0]  mp7_r;
  result_t     r8_r;
  logic [31:0] q1460_prod;
  logic [2:0]  cent_cnt;
  logic        era_last;
  logic [17:0] num4_nxt;
  logic [24:0] hour_prod;
  logic [4:0]  hour4_nxt;
  logic [32:0] yoe_prod;
  logic [8:0]  yoe5_nxt;
  logic [11:0] rem5_nxt;
  logic [1:0]  cyc_cnt;
  logic [8:0]  doy6_nxt;
  logic [19:0] min_prod;
  logic [5:0]  min6_nxt;
  logic [10:0] mp_num;
  logic [21:0] mp_prod;
  logic [3:0]  mp7_nxt;
  logic [5:0]  sec7_nxt;
  logic [4:0]  dd;
  logic [3:0]  mm;
  logic [11:0] yy;

  // First day of each month counted from March 1
  function automatic logic [8:0] month_start(logic [3:0] mp);
    case (mp)
      4'd0:    month_start = 9'd0;
      4'd1:    month_start = 9'd31;
      4'd2:    month_start = 9'd61;
      4'd3:    month_start = 9'd92;
      4'd4:    month_start = 9'd122;
      4'd5:    month_start = 9'd153;
      4'd6:    month_start = 9'd184;
      4'd7:    month_start = 9'd214;
      4'd8:    month_start = 9'd245;
      4'd9:    month_start = 9'd275;
      4'd10:   month_start = 9'd306;
      default: month_start = 9'd337;
    endcase
  endfunction

  assign adv      = !(v8_r && out_stall);
  assign in_stall = !adv;

  ntpcal_split u_split (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid), .in_ntp(in_ntp_seconds),
    .out_vld(sv), .out_data(sd)
  );

  // Stage four: leap-day corrected era day, hour of day
  always_comb begin
    q1460_prod = 32'(sd.doe[17:2]) * 32'(RECIP_365);
    cent_cnt   = 3'(sd.doe >= DAYS_PER_100Y) + 3'(sd.doe >= DAYS_PER_200Y) +
                 3'(sd.doe >= DAYS_PER_300Y) + 3'(sd.doe >= ERA_LAST_DAY);
    era_last   = (sd.doe == ERA_LAST_DAY);
    num4_nxt   = sd.doe - 18'(q1460_prod >> RECIP_365_SHIFT) + 18'(cent_cnt) -
                 18'(era_last);
    hour_prod  = 25'(sd.sod[16:4]) * 25'(RECIP_225);
    hour4_nxt  = 5'(hour_prod >> RECIP_225_SHIFT);
  end

  // Stage five: year of era, seconds within the hour
  always_comb begin
    yoe_prod = 33'(num4_r) * 33'(RECIP_365);
    yoe5_nxt = 9'(yoe_prod >> RECIP_365_SHIFT);
    rem5_nxt = 12'(d4_r.sod - 17'(hour4_r) * SECS_PER_HOUR);
  end

  // Stage six: day of year from March 1, minute of hour
  always_comb begin
    cyc_cnt  = 2'(yoe5_r >= 9'd100) + 2'(yoe5_r >= 9'd200) + 2'(yoe5_r >= 9'd300);
    doy6_nxt = 9'(doe5_r - (18'(yoe5_r) * DAYS_PER_YEAR + 18'(yoe5_r[8:2]) -
               18'(cyc_cnt)));
    min_prod = 20'(rem5_r[11:2]) * 20'(RECIP_15);
    min6_nxt = 6'(min_prod >> RECIP_15_SHIFT);
  end

  // Stage seven: month from March, second of minute
  always_comb begin
    mp_num   = 11'(doy6_r) * 11'd5 + 11'd2;
    mp_prod  = 22'(mp_num) * 22'(RECIP_153);
    mp7_nxt  = 4'(mp_prod >> RECIP_153_SHIFT);
    sec7_nxt = 6'(rem6_r - 12'(min6_r) * SECS_PER_MIN);
  end

  // Stage eight: day of month, calendar month and year
  always_comb begin
    dd = 5'(doy7_r - month_start(mp7_r) + 9'd1);
    mm = (mp7_r < 4'd10) ? mp7_r + 4'd3 : mp7_r - 4'd9;
    yy = BASE_YEAR + (era7_r ? YEARS_PER_ERA : 12'd0) + 12'(yoe7_r) +
         ((mm <= 4'd2) ? 12'd1 : 12'd0);
  end

  // Advance the valid bits of stages four to eight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (adv) begin
      v4_r <= sv;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_r    <= sd;
      num4_r  <= num4_nxt;
      hour4_r <= hour4_nxt;
      unix5_r <= d4_r.unix_seconds;
      era5_r  <= d4_r.era_hi;
      doe5_r  <= d4_r.doe;
      hour5_r <= hour4_r;
      yoe5_r  <= yoe5_nxt;
      rem5_r  <= rem5_nxt;
      unix6_r <= unix5_r;
      era6_r  <= era5_r;
      yoe6_r  <= yoe5_r;
      hour6_r <= hour5_r;
      rem6_r  <= rem5_r;
      doy6_r  <= doy6_nxt;
      min6_r  <= min6_nxt;
      unix7_r <= unix6_r;
      era7_r  <= era6_r;
      yoe7_r  <= yoe6_r;
      hour7_r <= hour6_r;
      min7_r  <= min6_r;
      sec7_r  <= sec7_nxt;
      doy7_r  <= doy6_r;
      mp7_r   <= mp7_nxt;
      r8_r.unix_seconds <= unix7_r;
      r8_r.year   <= yy;
      r8_r.month  <= mm;
      r8_r.day    <= dd;
      r8_r.hour   <= hour7_r;
      r8_r.minute <= min7_r;
      r8_r.second <= sec7_r;
    end
  end

  assign out_valid        = v8_r;
  assign out_unix_seconds = r8_r.unix_seconds;
  assign out_year         = r8_r.year;
  assign out_month        = r8_r.month;
  assign out_day          = r8_r.day;
  assign out_hour         = r8_r.hour;
  assign out_minute       = r8_r.minute;
  assign out_second       = r8_r.second;

endmodule

>>> design/ntpcal_checker.sv
// Checker: port-level properties of the converter, bound to the top level
`include "assert_macros.svh"
module ntpcal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_month,
  input logic [5:0]  out_second
);
  `ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_IMPL(a_month_rng, clk, rst_n, out_valid, out_month >= 4'd1 && out_month <= 4'd12)
  `ASSERT_IMPL(a_sec_rng, clk, rst_n, out_valid, out_second <= 6'd59)
endmodule

bind ntp_seconds_to_calendar ntpcal_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_month(out_month), .out_second(out_second)
);
